// ----- rtl/core/console_argument_tokenizer_core_assert.svh -----
// assertion macros for the argument tokenizer
`ifndef CONSOLE_ARGUMENT_TOKENIZER_CORE_ASSERT_SVH
`define CONSOLE_ARGUMENT_TOKENIZER_CORE_ASSERT_SVH

// checked at every edge, reset included
`define CAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// checked outside reset
`define CAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ----- rtl/core/cat_pkg.sv -----
// shared types, codes and helpers of the argument tokenizer
package cat_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_TOKEN_END = 2'd1;
  localparam logic [1:0] KIND_CMD_END   = 2'd2;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;

  localparam int unsigned MaxResults = 4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] item_kind;
    logic [7:0] token_byte;
    logic       run_last;
  } out_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [2:0]                  count;
    out_t [MaxResults-1:0]       items;
  } bundle_t;

  // queue control driven by the back end and seen by the queue
  typedef struct packed {
    logic valid;
    logic pop;
  } head_ctl_t;

  function automatic bundle_t add_item(bundle_t b, logic [1:0] kind, logic [7:0] byt);
    bundle_t r;
    r = b;
    if (b.count < 3'(MaxResults)) begin
      r.items[b.count[1:0]].item_kind  = kind;
      r.items[b.count[1:0]].token_byte = byt;
      r.items[b.count[1:0]].run_last   = 1'b0;
      r.count = b.count + 3'd1;
    end
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

// ----- rtl/core/cat_front.sv -----
// front end: classifies each byte, keeps scan state, builds the result bundle
module cat_front import cat_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  in_t     entry,
  input  logic    q_full,
  output logic    full,
  output logic    q_push,
  output bundle_t q_data
);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_QUOTE  = 2'd1,
    MODE_BLOCK  = 2'd2,
    MODE_LINE   = 2'd3
  } mode_t;

  mode_t   scan_mode, scan_mode_next;
  logic    slash_held, slash_held_next;
  logic    escape_held, escape_held_next;
  logic    star_held, star_held_next;
  logic    token_open, token_open_next;
  bundle_t bundle;
  logic    accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    logic [7:0] c;
    logic       fin;
    logic       done;
    c = entry.text_byte;
    fin = entry.final_byte;
    done = 1'b0;
    bundle = '0;
    scan_mode_next   = scan_mode;
    slash_held_next  = slash_held;
    escape_held_next = escape_held;
    star_held_next   = star_held;
    token_open_next  = token_open;

    unique case (scan_mode)
      MODE_NORMAL: begin
        if (escape_held) begin
          escape_held_next = 1'b0;
          bundle = add_item(bundle, KIND_BYTE, c);
          token_open_next = 1'b1;
          done = 1'b1;
        end else if (slash_held) begin
          slash_held_next = 1'b0;
          if (c == CH_SLASH || c == CH_STAR) begin
            if (token_open_next) begin
              bundle = add_item(bundle, KIND_TOKEN_END, 8'd0);
              token_open_next = 1'b0;
            end
            scan_mode_next = (c == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
            star_held_next = 1'b0;
            done = 1'b1;
          end else begin
            bundle = add_item(bundle, KIND_BYTE, CH_SLASH);
            token_open_next = 1'b1;
          end
        end
        if (!done) begin
          if (is_space(c)) begin
            if (token_open_next) begin
              bundle = add_item(bundle, KIND_TOKEN_END, 8'd0);
              token_open_next = 1'b0;
            end
          end else if (c == CH_QUOTE) begin
            token_open_next = 1'b1;
            scan_mode_next = MODE_QUOTE;
          end else if (c == CH_BACKSLASH && !fin) begin
            escape_held_next = 1'b1;
          end else if (c == CH_SLASH && !fin) begin
            slash_held_next = 1'b1;
          end else begin
            bundle = add_item(bundle, KIND_BYTE, c);
            token_open_next = 1'b1;
          end
        end
      end
      MODE_QUOTE: begin
        if (escape_held) begin
          escape_held_next = 1'b0;
          bundle = add_item(bundle, KIND_BYTE, c);
          token_open_next = 1'b1;
        end else if (c == CH_QUOTE) begin
          scan_mode_next = MODE_NORMAL;
        end else if (c == CH_BACKSLASH && !fin) begin
          escape_held_next = 1'b1;
        end else begin
          bundle = add_item(bundle, KIND_BYTE, c);
          token_open_next = 1'b1;
        end
      end
      MODE_BLOCK: begin
        if (star_held && c == CH_SLASH) begin
          scan_mode_next = MODE_NORMAL;
          star_held_next = 1'b0;
        end else begin
          star_held_next = (c == CH_STAR);
        end
      end
      MODE_LINE: begin
        done = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase

    if (fin) begin
      if (token_open_next) begin
        bundle = add_item(bundle, KIND_TOKEN_END, 8'd0);
      end
      bundle = add_item(bundle, KIND_CMD_END, 8'd0);
      scan_mode_next   = MODE_NORMAL;
      slash_held_next  = 1'b0;
      escape_held_next = 1'b0;
      star_held_next   = 1'b0;
      token_open_next  = 1'b0;
    end

    if (bundle.count != 3'd0) begin
      bundle.items[2'(bundle.count - 3'd1)].run_last = 1'b1;
    end
  end

  assign q_push = accept && (bundle.count != 3'd0);
  assign q_data = bundle;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode   <= MODE_NORMAL;
      slash_held  <= 1'b0;
      escape_held <= 1'b0;
      star_held   <= 1'b0;
      token_open  <= 1'b0;
    end else if (accept) begin
      scan_mode   <= scan_mode_next;
      slash_held  <= slash_held_next;
      escape_held <= escape_held_next;
      star_held   <= star_held_next;
      token_open  <= token_open_next;
    end
  end

endmodule

// ----- rtl/core/cat_queue.sv -----
// short bundle queue between front and back end
module cat_queue import cat_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr,
  input  bundle_t   wr_data,
  output logic      full,
  input  head_ctl_t ctl_in,
  output logic      valid,
  output bundle_t   head
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bundle_t           mem [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   fill;
  logic              do_wr;
  logic              do_rd;

  assign full  = (fill == CntW'(Depth));
  assign valid = (fill != '0);
  assign head  = mem[rd_ptr];
  assign do_wr = wr && !full;
  assign do_rd = ctl_in.pop && ctl_in.valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + CntW'(do_wr) - CntW'(do_rd);
    end
  end

endmodule

// ----- rtl/core/cat_back.sv -----
// back end: hands out the results of the head bundle one transfer at a time
module cat_back import cat_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  bundle_t   head,
  output head_ctl_t ctl,
  input  logic      pop,
  output logic      empty,
  output out_t      result
);

  logic [1:0] idx;
  logic       last;
  logic       take;

  assign empty  = !q_valid;
  assign result = head.items[idx];
  assign last   = ({1'b0, idx} == head.count - 3'd1);
  assign take   = pop && q_valid;

  assign ctl.valid = q_valid;
  assign ctl.pop   = take && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

// ----- rtl/core/console_argument_tokenizer_core.sv -----
// top level of the console argument tokenizer
// Takes one command byte per cycle while full is low and delivers token bytes,
// token ends and a command end, one result per pop. The front end accepts a
// byte every cycle while the bundle queue has room; each accepted byte yields
// 0 to 4 results, and the back end drains them one per cycle while pop is held
// (bytes with no result are not written to the queue).
// Sustained rate is set by the back end's one-result-per-cycle serializer;
// QueueDepth bundles of slack sit between the two halves.
module console_argument_tokenizer_core import cat_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  entry,
  output logic empty,
  input  logic pop,
  output out_t result
);

  logic      q_full;
  logic      q_push;
  bundle_t   q_data;
  logic      q_valid;
  bundle_t   q_head;
  head_ctl_t ctl;

  cat_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .entry  (entry),
    .q_full (q_full),
    .full   (full),
    .q_push (q_push),
    .q_data (q_data)
  );

  cat_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_data),
    .full    (q_full),
    .ctl_in  (ctl),
    .valid   (q_valid),
    .head    (q_head)
  );

  cat_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (q_head),
    .ctl     (ctl),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// ----- rtl/core/cat_checker.sv -----
// port-level checks of the argument tokenizer and their binding
`include "console_argument_tokenizer_core_assert.svh"

module cat_checker import cat_pkg::*; (
  input logic clk,
  input logic rst,
  input logic empty,
  input logic pop,
  input out_t result
);

  logic is_mark;
  logic is_end;

  assign is_mark = !empty && (result.item_kind != KIND_BYTE);
  assign is_end  = !empty && (result.item_kind == KIND_CMD_END);

  `CAT_ASSERT_ALWAYS(a_reset_empty, rst |=> empty, "queue not empty after reset")
  `CAT_ASSERT(a_kind_legal, !empty |-> (result.item_kind <= KIND_CMD_END), "bad result kind")
  `CAT_ASSERT(a_mark_no_byte, is_mark |-> (result.token_byte == 8'd0), "mark carries a byte")
  `CAT_ASSERT(a_cmd_end_last, is_end |-> result.run_last, "command end not last of its byte")
  `CAT_ASSERT(a_stall_hold, (!empty && !pop) |=> (!empty && $stable(result)), "result changed")

endmodule

bind console_argument_tokenizer_core cat_checker u_cat_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
